[sv/sth_pkg.sv]
package sth_pkg;

  localparam int FIELD_W = 48;
  localparam int AXES    = 3;
  localparam int NCROSS  = 4;

endpackage

[sv/sth_prep.sv]
module sth_prep #(
  parameter int W = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [sth_pkg::FIELD_W-1:0]   vertex_zero,
  input  logic [sth_pkg::FIELD_W-1:0]   vertex_one,
  input  logic [sth_pkg::FIELD_W-1:0]   vertex_two,
  input  logic [sth_pkg::FIELD_W-1:0]   seg_origin,
  input  logic [sth_pkg::FIELD_W-1:0]   seg_direction,
  output logic                          out_valid,
  output logic signed [W:0]             e0 [sth_pkg::AXES],
  output logic signed [W:0]             e1 [sth_pkg::AXES],
  output logic signed [W:0]             a  [sth_pkg::AXES],
  output logic signed [W:0]             b  [sth_pkg::AXES],
  output logic signed [W:0]             c  [sth_pkg::AXES],
  output logic signed [W-1:0]           d  [sth_pkg::AXES]
);
  import sth_pkg::*;

  localparam int DW = W + 1;
  localparam int PW = (3 * W > FIELD_W) ? 3 * W : FIELD_W;

  // z bits above the 48-bit field read as zero
  logic [PW-1:0] ext [5];
  logic signed [W-1:0] v0 [AXES];
  logic signed [W-1:0] v1 [AXES];
  logic signed [W-1:0] v2 [AXES];
  logic signed [W-1:0] org [AXES];
  logic signed [W-1:0] dir [AXES];

  assign ext[0] = PW'(vertex_zero);
  assign ext[1] = PW'(vertex_one);
  assign ext[2] = PW'(vertex_two);
  assign ext[3] = PW'(seg_origin);
  assign ext[4] = PW'(seg_direction);

  for (genvar k = 0; k < AXES; k++) begin : g_axis
    assign v0[k]  = $signed(ext[0][k*W +: W]);
    assign v1[k]  = $signed(ext[1][k*W +: W]);
    assign v2[k]  = $signed(ext[2][k*W +: W]);
    assign org[k] = $signed(ext[3][k*W +: W]);
    assign dir[k] = $signed(ext[4][k*W +: W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < AXES; k++) begin
      e0[k] <= DW'(v1[k]) - DW'(v0[k]);
      e1[k] <= DW'(v2[k]) - DW'(v1[k]);
      a[k]  <= DW'(v0[k]) - DW'(org[k]);
      b[k]  <= DW'(v1[k]) - DW'(org[k]);
      c[k]  <= DW'(v2[k]) - DW'(org[k]);
      d[k]  <= dir[k];
    end
  end

endmodule

[sv/sth_cross.sv]
module sth_cross #(
  parameter int W = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [W:0]       e0 [sth_pkg::AXES],
  input  logic signed [W:0]       e1 [sth_pkg::AXES],
  input  logic signed [W:0]       a  [sth_pkg::AXES],
  input  logic signed [W:0]       b  [sth_pkg::AXES],
  input  logic signed [W:0]       c  [sth_pkg::AXES],
  input  logic signed [W-1:0]     d  [sth_pkg::AXES],
  output logic                    out_valid,
  output logic signed [2*W+2:0]   cr [sth_pkg::NCROSS][sth_pkg::AXES],
  output logic signed [W:0]       a_q [sth_pkg::AXES],
  output logic signed [W-1:0]     d_q [sth_pkg::AXES]
);
  import sth_pkg::*;

  localparam int DW = W + 1;
  localparam int MW = 2 * DW;
  localparam int CW = 2 * DW + 1;

  // pairs: normal (e0 x e1), then (a x b), (b x c), (c x a)
  logic signed [DW-1:0] lhs [NCROSS][AXES];
  logic signed [DW-1:0] rhs [NCROSS][AXES];
  logic signed [MW-1:0] pp  [NCROSS][AXES];
  logic signed [MW-1:0] pq  [NCROSS][AXES];

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      lhs[0][k] = e0[k];
      rhs[0][k] = e1[k];
      lhs[1][k] = a[k];
      rhs[1][k] = b[k];
      lhs[2][k] = b[k];
      rhs[2][k] = c[k];
      lhs[3][k] = c[k];
      rhs[3][k] = a[k];
    end
  end

  for (genvar p = 0; p < NCROSS; p++) begin : g_pair
    for (genvar k = 0; k < AXES; k++) begin : g_axis
      localparam int J = (k + 1) % AXES;
      localparam int L = (k + 2) % AXES;
      assign pp[p][k] = lhs[p][J] * rhs[p][L];
      assign pq[p][k] = lhs[p][L] * rhs[p][J];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NCROSS; p++) begin
      for (int k = 0; k < AXES; k++) begin
        cr[p][k] <= CW'(pp[p][k]) - CW'(pq[p][k]);
      end
    end
    for (int k = 0; k < AXES; k++) begin
      a_q[k] <= a[k];
      d_q[k] <= d[k];
    end
  end

endmodule

[sv/sth_dot.sv]
module sth_dot #(
  parameter int W = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [2*W+2:0]   cr [sth_pkg::NCROSS][sth_pkg::AXES],
  input  logic signed [W:0]       a  [sth_pkg::AXES],
  input  logic signed [W-1:0]     d  [sth_pkg::AXES],
  output logic                    out_valid,
  output logic signed [3*W+5:0]   den,
  output logic signed [3*W+5:0]   num,
  output logic signed [3*W+5:0]   wt [sth_pkg::AXES]
);
  import sth_pkg::*;

  localparam int DW  = W + 1;
  localparam int CW  = 2 * DW + 1;
  localparam int PRW = CW + DW;
  localparam int SW  = PRW + 2;

  logic signed [PRW-1:0] prod_den [AXES];
  logic signed [PRW-1:0] prod_num [AXES];
  logic signed [PRW-1:0] prod_w   [AXES][AXES];
  logic                  prod_valid;

  // stage: products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < AXES; k++) begin
      prod_den[k] <= PRW'(cr[0][k]) * PRW'(d[k]);
      prod_num[k] <= PRW'(cr[0][k]) * PRW'(a[k]);
      for (int i = 0; i < AXES; i++) begin
        prod_w[i][k] <= PRW'(cr[i+1][k]) * PRW'(d[k]);
      end
    end
  end

  // stage: sums
  always_ff @(posedge clk) begin
    den <= SW'(prod_den[0]) + SW'(prod_den[1]) + SW'(prod_den[2]);
    num <= SW'(prod_num[0]) + SW'(prod_num[1]) + SW'(prod_num[2]);
    for (int i = 0; i < AXES; i++) begin
      wt[i] <= SW'(prod_w[i][0]) + SW'(prod_w[i][1]) + SW'(prod_w[i][2]);
    end
  end

endmodule

[sv/sth_decide.sv]
module sth_decide #(
  parameter int W = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [3*W+5:0]   den,
  input  logic signed [3*W+5:0]   num,
  input  logic signed [3*W+5:0]   wt [sth_pkg::AXES],
  output logic                    out_valid,
  output logic                    hit
);
  import sth_pkg::*;

  localparam int SW  = 3 * W + 6;
  localparam int DFW = SW + 1;

  logic signed [DFW-1:0] diff;
  logic                  den_neg;
  logic                  num_ok;
  logic                  range_ok;
  logic [AXES-1:0]       edge_ok;
  logic                  hit_next;

  // zero or same sign as den passes each test
  always_comb begin
    diff     = DFW'(den) - DFW'(num);
    den_neg  = den[SW-1];
    num_ok   = (num == '0) || (num[SW-1] == den_neg);
    range_ok = (diff == '0) || (diff[DFW-1] == den_neg);
    for (int i = 0; i < AXES; i++) begin
      edge_ok[i] = (wt[i] == '0) || (wt[i][SW-1] == den_neg);
    end
    hit_next = (den != '0) && num_ok && range_ok && (&edge_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    hit <= hit_next;
  end

endmodule

[sv/segment_triangle_hit_test.sv]
// Segment / triangle hit test.
// Input: an item is taken on each rising edge with start high and busy low.
// busy is held low: the pipeline takes a new item every cycle, so the
// sustained rate is one item per clock.
// Fields are packed x, y, z signed fixed-point coordinates, COORD_WIDTH bits
// each; bits above the z coordinate are ignored.
// Output: done is high for exactly one cycle per item, with hit valid in
// that cycle. The item passes through five register stages (differences, cross
// products, dot-product terms, sums, sign decision) before done rises.
// Results leave in input order.
// The receiver has no back-pressure; a result not taken in its cycle is gone.
// Reset clears the valid bits of every stage, so no done appears until a
// new item arrives; items in flight at reset are dropped.
module segment_triangle_hit_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [sth_pkg::FIELD_W-1:0]  vertex_zero,
  input  logic [sth_pkg::FIELD_W-1:0]  vertex_one,
  input  logic [sth_pkg::FIELD_W-1:0]  vertex_two,
  input  logic [sth_pkg::FIELD_W-1:0]  seg_origin,
  input  logic [sth_pkg::FIELD_W-1:0]  seg_direction,
  output logic                         done,
  output logic                         hit
);
  import sth_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int CW = 2 * DW + 1;
  localparam int SW = 3 * W + 6;

  logic                 s1_valid;
  logic signed [DW-1:0] e0 [AXES];
  logic signed [DW-1:0] e1 [AXES];
  logic signed [DW-1:0] a  [AXES];
  logic signed [DW-1:0] b  [AXES];
  logic signed [DW-1:0] c  [AXES];
  logic signed [W-1:0]  d  [AXES];

  logic                 s2_valid;
  logic signed [CW-1:0] cr  [NCROSS][AXES];
  logic signed [DW-1:0] a_q [AXES];
  logic signed [W-1:0]  d_q [AXES];

  logic                 s4_valid;
  logic signed [SW-1:0] den;
  logic signed [SW-1:0] num;
  logic signed [SW-1:0] wt [AXES];

  assign busy = 1'b0;

  sth_prep #(.W(W)) u_prep (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start & ~busy),
    .vertex_zero   (vertex_zero),
    .vertex_one    (vertex_one),
    .vertex_two    (vertex_two),
    .seg_origin    (seg_origin),
    .seg_direction (seg_direction),
    .out_valid     (s1_valid),
    .e0            (e0),
    .e1            (e1),
    .a             (a),
    .b             (b),
    .c             (c),
    .d             (d)
  );

  sth_cross #(.W(W)) u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .e0        (e0),
    .e1        (e1),
    .a         (a),
    .b         (b),
    .c         (c),
    .d         (d),
    .out_valid (s2_valid),
    .cr        (cr),
    .a_q       (a_q),
    .d_q       (d_q)
  );

  sth_dot #(.W(W)) u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .cr        (cr),
    .a         (a_q),
    .d         (d_q),
    .out_valid (s4_valid),
    .den       (den),
    .num       (num),
    .wt        (wt)
  );

  sth_decide #(.W(W)) u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_valid),
    .den       (den),
    .num       (num),
    .wt        (wt),
    .out_valid (done),
    .hit       (hit)
  );

endmodule

[verif/tb_segment_triangle_hit_test.sv]
`timescale 1ns / 100ps

module tb_segment_triangle_hit_test;

  localparam int COORD_W    = 16;
  localparam int QUIET_MAX  = 2000;
  localparam int DRAIN_WAIT = 10;

  typedef logic [sth_pkg::FIELD_W-1:0] field_t;
  typedef struct { longint x, y, z; } vec3_t;

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  field_t vertex_zero;
  field_t vertex_one;
  field_t vertex_two;
  field_t seg_origin;
  field_t seg_direction;
  logic   done;
  logic   hit;

  bit expected_hits[$];
  int errors;
  int quiet_cycles;
  bit pauses_on;
  bit no_idle;
  bit want_hit;

  segment_triangle_hit_test #(.COORD_WIDTH(COORD_W)) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .vertex_zero   (vertex_zero),
    .vertex_one    (vertex_one),
    .vertex_two    (vertex_two),
    .seg_origin    (seg_origin),
    .seg_direction (seg_direction),
    .done          (done),
    .hit           (hit)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic vec3_t unpack_point(field_t w);
    vec3_t p;
    p.x = longint'($signed(w[0 +: COORD_W]));
    p.y = longint'($signed(w[COORD_W +: COORD_W]));
    p.z = longint'($signed(w[2*COORD_W +: COORD_W]));
    return p;
  endfunction

  function automatic vec3_t vec_sub(vec3_t a, vec3_t b);
    vec3_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec3_t vec_cross(vec3_t a, vec3_t b);
    vec3_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic longint vec_dot(vec3_t a, vec3_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic int sign_of(longint v);
    return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
  endfunction

  // exact integer decision, no division: t range via num/den signs,
  // edge tests via signed volumes against the sign of den
  function automatic bit segment_crosses_triangle(field_t f0, field_t f1, field_t f2,
                                                  field_t fo, field_t fd);
    vec3_t  v0, v1, v2, o, d, n, a, b, c;
    longint den, num;
    int     sd, sn;
    v0  = unpack_point(f0);
    v1  = unpack_point(f1);
    v2  = unpack_point(f2);
    o   = unpack_point(fo);
    d   = unpack_point(fd);
    n   = vec_cross(vec_sub(v1, v0), vec_sub(v2, v1));
    den = vec_dot(n, d);
    num = vec_dot(n, vec_sub(v0, o));
    sd  = sign_of(den);
    sn  = sign_of(num);
    if (sd == 0 || sn == -sd)
      return 1'b0;
    if (sign_of(den - num) * sd < 0)
      return 1'b0;
    a = vec_sub(v0, o);
    b = vec_sub(v1, o);
    c = vec_sub(v2, o);
    return (sign_of(vec_dot(d, vec_cross(a, b))) != -sd) &&
           (sign_of(vec_dot(d, vec_cross(b, c))) != -sd) &&
           (sign_of(vec_dot(d, vec_cross(c, a))) != -sd);
  endfunction

  function automatic field_t pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic field_t rand_word();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic field_t rand_point(int span);
    return pack3(rand_between(-span, span), rand_between(-span, span),
                 rand_between(-span, span));
  endfunction

  // called at a rising edge; returns at the edge that takes the item
  task automatic send_item(field_t f0, field_t f1, field_t f2, field_t fo, field_t fd);
    start         <= 1'b1;
    vertex_zero   <= f0;
    vertex_one    <= f1;
    vertex_two    <= f2;
    seg_origin    <= fo;
    seg_direction <= fd;
    @(negedge clk);
    while (busy)
      @(negedge clk);
    expected_hits.push_back(segment_crosses_triangle(f0, f1, f2, fo, fd));
    @(posedge clk);
  endtask

  task automatic maybe_pause();
    if (pauses_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_hits.size() == 0) begin
        errors++;
        $display("%0t ERROR unexpected result: expected none actual hit=%0b", $time, hit);
      end else begin
        want_hit = expected_hits.pop_front();
        if (hit !== want_hit) begin
          errors++;
          $display("%0t ERROR hit mismatch: expected %0b actual %0b", $time, want_hit, hit);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("%0t timeout: no item moved for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic test_directed_cases();
    field_t t0, t1, t2;
    t0 = pack3(0, 0, 0);
    t1 = pack3(100, 0, 0);
    t2 = pack3(0, 100, 0);
    send_item('0, '0, '0, '0, '0);
    send_item('1, '1, '1, '1, '1);
    send_item(t0, t1, t2, pack3(10, 10, -50), pack3(0, 0, 100));
    send_item(t0, t1, t2, pack3(10, 10, 50), pack3(0, 0, -100));
    // segment lying in the plane, and one parallel above it
    send_item(t0, t1, t2, pack3(10, 10, 0), pack3(50, 0, 0));
    send_item(t0, t1, t2, pack3(10, 10, 5), pack3(50, 20, 0));
    // collinear and coincident vertices
    send_item(t0, t1, pack3(200, 0, 0), pack3(10, 0, -50), pack3(0, 0, 100));
    send_item(t1, t1, t2, pack3(10, 10, -50), pack3(0, 0, 100));
    // zero-length segment
    send_item(t0, t1, t2, pack3(10, 10, 0), pack3(0, 0, 0));
    // crossing at either end and just past it
    send_item(t0, t1, t2, pack3(10, 10, 0), pack3(0, 0, 100));
    send_item(t0, t1, t2, pack3(10, 10, -100), pack3(0, 0, 100));
    send_item(t0, t1, t2, pack3(10, 10, -101), pack3(0, 0, 100));
    send_item(t0, t1, t2, pack3(10, 10, 1), pack3(0, 0, 100));
    // on an edge, on the hypotenuse, on a vertex, just outside
    send_item(t0, t1, t2, pack3(50, 0, -50), pack3(0, 0, 100));
    send_item(t0, t1, t2, pack3(50, 50, -50), pack3(0, 0, 100));
    send_item(t0, t1, t2, pack3(0, 0, -50), pack3(0, 0, 100));
    send_item(t0, t1, t2, pack3(51, 50, -50), pack3(0, 0, 100));
    send_item(t0, t2, t1, pack3(-1, 10, 30), pack3(0, 0, -60));
    // coordinate extremes
    t0 = pack3(-32768, -32768, 0);
    t1 = pack3(32767, -32768, 0);
    t2 = pack3(-32768, 32767, 0);
    send_item(t0, t1, t2, pack3(-1, -1, -32767), pack3(0, 0, 32767));
    send_item(t0, t1, t2, pack3(0, 0, -32768), pack3(0, 0, 32767));
    send_item(t0, t1, t2, pack3(-32768, -32768, 32767), pack3(0, 0, -32768));
    send_item(pack3(32767, 32767, 32767), pack3(-32768, 32767, -32768),
              pack3(32767, -32768, -32768), pack3(-32768, -32768, 32767),
              pack3(32767, 32767, -32768));
    start <= 1'b0;
    @(posedge clk);
  endtask

  // triangle with a point near its face, segment along a line through that point
  task automatic test_random_crossings(int count);
    int     span, wa, wb, wc, ws, m, dspan;
    int     px, py, pz, qx, qy, qz;
    vec3_t  a, b, c;
    field_t f0, f1, f2;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0 && !no_idle)
        pauses_on = ($urandom_range(3) != 0);
      span  = ($urandom_range(4) == 0) ? 8000 : rand_between(2, 200);
      dspan = (span / 4 > 1) ? span / 4 : 1;
      f0 = rand_point(span);
      f1 = rand_point(span);
      f2 = rand_point(span);
      a  = unpack_point(f0);
      b  = unpack_point(f1);
      c  = unpack_point(f2);
      case ($urandom_range(3))
        0: begin
          wa = 1; wb = 0; wc = 0;
        end
        1: begin
          wa = 1; wb = 1; wc = 0;
        end
        default: begin
          wa = $urandom_range(8); wb = $urandom_range(8); wc = $urandom_range(8);
        end
      endcase
      if ($urandom_range(1)) begin
        m = wa; wa = wc; wc = wb; wb = m;
      end
      ws = wa + wb + wc;
      if (ws == 0) begin
        wa = 1;
        ws = 1;
      end
      px = int'((wa * a.x + wb * b.x + wc * c.x) / ws);
      py = int'((wa * a.y + wb * b.y + wc * c.y) / ws);
      pz = int'((wa * a.z + wb * b.z + wc * c.z) / ws);
      qx = rand_between(-dspan, dspan);
      qy = rand_between(-dspan, dspan);
      qz = rand_between(-dspan, dspan);
      m  = ($urandom_range(7) == 0) ? rand_between(-1, 5) : rand_between(0, 4);
      send_item(f0, f1, f2, pack3(px - qx * m, py - qy * m, pz - qz * m),
                pack3(4 * qx, 4 * qy, 4 * qz));
      maybe_pause();
    end
    if (!no_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic test_random_noise(int count);
    field_t f0, f1, f2;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: send_item(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
        1: send_item(rand_point(50), rand_point(50), rand_point(50),
                     rand_point(50), rand_point(100));
        2: begin
          f0 = rand_point(300);
          f1 = rand_point(300);
          f2 = ($urandom_range(1)) ? f1 : f0;
          send_item(f0, f1, f2, rand_point(300), rand_point(600));
        end
        default: send_item(rand_word(), rand_word(), rand_word(),
                           rand_point(1000), pack3(0, 0, 0));
      endcase
      maybe_pause();
    end
    if (!no_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    errors        = 0;
    pauses_on     = 1'b1;
    no_idle       = 1'b0;
    rst           <= 1'b1;
    start         <= 1'b0;
    vertex_zero   <= '0;
    vertex_one    <= '0;
    vertex_two    <= '0;
    seg_origin    <= '0;
    seg_direction <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_crossings(650);
    test_random_noise(250);
    // back-to-back stream, no gaps
    pauses_on = 1'b0;
    no_idle   = 1'b1;
    test_random_crossings(150);
    test_random_noise(80);
    start <= 1'b0;

    while (expected_hits.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_hits.size() != 0) begin
      errors++;
      $display("%0t ERROR %0d results missing: expected hit=%0b actual none",
               $time, expected_hits.size(), expected_hits[0]);
    end
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
